/* hdl/ptva_pkg.sv */
// Shared types, constants and tables for the planar thrust-vector allocator.
package ptva_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_N   = 24;
    localparam int ITER_N   = (CORDIC_ITERATIONS > ATAN_N) ? ATAN_N : CORDIC_ITERATIONS;
    localparam int SQRT_N   = 32;
    localparam int DIV_N    = 16;
    localparam int PIPE_N   = 4 + SQRT_N + DIV_N;
    localparam int PITCH_STG = 3 + ITER_N;
    localparam int PROD_STG = 4 + SQRT_N;

    localparam logic [14:0] PITCH_LIMIT_MAX = 15'd25734;
    localparam logic [15:0] THR_FULL = 16'd32768;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_MASS  = 2'd2;
    localparam logic [1:0] ST_NOCFG = 2'd3;

    localparam logic [2:0] ADDR_MAX_THRUST = 3'd0;
    localparam logic [2:0] ADDR_MAX_PITCH  = 3'd4;

    // atan(2^-i), units of 2^-24 rad
    localparam logic [25:0] ATAN_TAB [0:ATAN_N-1] = '{
        26'd13176795, 26'd7778716, 26'd4110060, 26'd2086331, 26'd1047214,
        26'd524117, 26'd262123, 26'd131069, 26'd65536, 26'd32768, 26'd16384,
        26'd8192, 26'd4096, 26'd2048, 26'd1024, 26'd512, 26'd256, 26'd128,
        26'd64, 26'd32, 26'd16, 26'd8, 26'd4, 26'd2
    };

    typedef struct packed {
        logic signed [31:0] accel_lateral;
        logic signed [31:0] accel_vertical;
        logic [31:0]        vehicle_mass;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pitch_cmd;
        logic [15:0]        throttle_cmd;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  err;
        logic        sat_neg;
        logic        zero;
        logic [31:0] mass;
    } t_side;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic               sat;
    } t_pitch;

endpackage

/* hdl/planar_thrust_vector_allocator.sv */
// Top level: pipelined thrust-vector allocator (CORDIC, square root, divider chains).
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------
//  command   | i_in_valid  / o_in_stall       | i_in_data  (t_in_item)
//  result    | o_out_valid / i_out_stall      | o_out_data (t_out_item)
//  config    | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
//  One transfer in per cycle while o_in_stall is low; the pipe depth is set by the
//  32-cell square-root chain followed by the 16-cell divider chain.
//  Reset (synchronous, i_rst_n low) clears the valid bits and both registers.
//  A stalled result freezes the whole pipe; o_in_stall rises only then.
module planar_thrust_vector_allocator
    import ptva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // ---------------- configuration registers ----------------
    logic [31:0] r_max_thrust;
    logic [14:0] r_max_pitch;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_thrust <= '0;
            r_max_pitch  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_MAX_THRUST: r_max_thrust <= pwdata;
                ADDR_MAX_PITCH:  r_max_pitch  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_MAX_THRUST: prdata = r_max_thrust;
            ADDR_MAX_PITCH:  prdata = {17'd0, r_max_pitch};
            default:         prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Whole pipe advances unless a finished result is being held.
    logic      r_out_vld;
    t_out_item r_out;
    logic      en;

    assign en          = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Valid bits and side data ride along every stage.
    logic  r_vld  [1:PIPE_N];
    t_side r_side [1:PIPE_N];

    // ---------------- stage 1: capture, classify ----------------
    t_side       n_side;
    logic [31:0] n_ax;
    logic [30:0] n_up;
    logic        nocfg;
    logic [31:0] r_ax;
    logic [30:0] r_up;
    logic        r_xneg;

    always_comb begin
        nocfg = (r_max_thrust == '0) || (r_max_pitch == '0) ||
                (r_max_pitch > PITCH_LIMIT_MAX);
        n_ax  = i_in_data.accel_lateral[31] ? (32'd0 - i_in_data.accel_lateral)
                                            : i_in_data.accel_lateral;
        n_up  = (i_in_data.accel_vertical[31]) ? 31'd0 : i_in_data.accel_vertical[30:0];
        n_side.err     = nocfg ? ST_NOCFG :
                         (i_in_data.vehicle_mass == '0) ? ST_MASS : ST_OK;
        n_side.sat_neg = i_in_data.accel_vertical[31];
        n_side.zero    = (i_in_data.accel_lateral == '0) && (n_up == '0);
        n_side.mass    = i_in_data.vehicle_mass;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax      <= n_ax;
            r_up      <= n_up;
            r_xneg    <= i_in_data.accel_lateral[31];
        end
    end

    // ---------------- stage 2: squares, CORDIC normalization ----------------
    logic [31:0] w_m;
    logic [4:0]  w_msb;
    logic [5:0]  w_sh;
    logic [41:0] w_ay;
    logic [63:0] r_sq_x, r_sq_u;
    logic signed [41:0] r_cx0, r_cy0;

    always_comb begin
        w_m   = (r_ax > {1'b0, r_up}) ? r_ax : {1'b0, r_up};
        w_msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (w_m[b]) w_msb = 5'(b);
        end
        // larger operand lands in [2^38, 2^39)
        w_sh = 6'd38 - {1'b0, w_msb};
        w_ay = 42'(r_ax) << w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x <= 64'(r_ax) * 64'(r_ax);
            r_sq_u <= 64'(r_up) * 64'(r_up);
            r_cx0  <= $signed(42'(r_up) << w_sh);
            r_cy0  <= r_xneg ? $signed(42'd0 - w_ay) : $signed(w_ay);
        end
    end

    // ---------------- CORDIC chain ----------------
    logic signed [41:0] w_cx [0:ITER_N];
    logic signed [41:0] w_cy [0:ITER_N];
    logic signed [26:0] w_cz [0:ITER_N];

    assign w_cx[0] = r_cx0;
    assign w_cy[0] = r_cy0;
    assign w_cz[0] = '0;

    for (genvar gi = 0; gi < ITER_N; gi++) begin : g_cordic
        ptva_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_idx (5'(gi)),
            .i_x   (w_cx[gi]),
            .i_y   (w_cy[gi]),
            .i_z   (w_cz[gi]),
            .o_x   (w_cx[gi+1]),
            .o_y   (w_cy[gi+1]),
            .o_z   (w_cz[gi+1])
        );
    end

    // Round to Q2.14 and clamp to the pitch limit.
    logic signed [26:0] w_zr;
    logic signed [16:0] w_pq, w_lim;
    t_pitch             n_pitch;
    t_pitch             r_pitch [PITCH_STG:PIPE_N];

    always_comb begin
        w_zr  = (w_cz[ITER_N] + 27'sd512) >>> 10;
        w_pq  = w_zr[16:0];
        w_lim = $signed({2'b00, r_max_pitch});
        if (w_pq > w_lim) begin
            n_pitch.pitch = w_lim[15:0];
            n_pitch.sat   = 1'b1;
        end else if (w_pq < -w_lim) begin
            n_pitch.pitch = 16'(-w_lim);
            n_pitch.sat   = 1'b1;
        end else begin
            n_pitch.pitch = w_pq[15:0];
            n_pitch.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch[PITCH_STG] <= n_pitch;
            for (int s = PITCH_STG + 1; s <= PIPE_N; s++) begin
                r_pitch[s] <= r_pitch[s-1];
            end
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic [63:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (en) r_sum <= r_sq_x + r_sq_u;
    end

    // ---------------- square-root chain, one bit per cell ----------------
    logic [63:0] w_srem  [0:SQRT_N];
    logic [31:0] w_sroot [0:SQRT_N];

    assign w_srem[0]  = r_sum;
    assign w_sroot[0] = '0;

    for (genvar gs = 0; gs < SQRT_N; gs++) begin : g_sqrt
        ptva_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_k    (5'(SQRT_N - 1 - gs)),
            .i_rem  (w_srem[gs]),
            .i_root (w_sroot[gs]),
            .o_rem  (w_srem[gs+1]),
            .o_root (w_sroot[gs+1])
        );
    end

    // ---------------- mass * magnitude, saturation test ----------------
    logic [63:0] r_prod;
    logic        r_thsat [PROD_STG+1:PIPE_N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 64'(r_side[PROD_STG-1].mass) * 64'(w_sroot[SQRT_N]);
            // ratio above one: M*G > T*2^16
            r_thsat[PROD_STG+1] <= r_prod > {16'd0, r_max_thrust, 16'd0};
            for (int s = PROD_STG + 2; s <= PIPE_N; s++) begin
                r_thsat[s] <= r_thsat[s-1];
            end
        end
    end

    // ---------------- divider chain: M*G / (2T) ----------------
    logic [48:0] w_drem [0:DIV_N];
    logic [32:0] w_dd   [0:DIV_N];
    logic [15:0] w_dq   [0:DIV_N];

    assign w_drem[0] = r_prod[48:0];
    assign w_dd[0]   = {r_max_thrust, 1'b0};
    assign w_dq[0]   = '0;

    for (genvar gd = 0; gd < DIV_N; gd++) begin : g_div
        ptva_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_k   (4'(DIV_N - 1 - gd)),
            .i_rem (w_drem[gd]),
            .i_d   (w_dd[gd]),
            .i_q   (w_dq[gd]),
            .o_rem (w_drem[gd+1]),
            .o_d   (w_dd[gd+1]),
            .o_q   (w_dq[gd+1])
        );
    end

    // ---------------- valid and side shift line ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= PIPE_N; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_in_valid;
            for (int s = 2; s <= PIPE_N; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= n_side;
            for (int s = 2; s <= PIPE_N; s++) r_side[s] <= r_side[s-1];
        end
    end

    // ---------------- output register ----------------
    t_side     w_fs;
    t_pitch    w_fp;
    logic      w_ft;
    t_out_item n_out;

    always_comb begin
        w_fs = r_side[PIPE_N];
        w_fp = r_pitch[PIPE_N];
        w_ft = r_thsat[PIPE_N];
        if (w_fs.err != ST_OK) begin
            n_out.pitch_cmd    = '0;
            n_out.throttle_cmd = '0;
            n_out.status       = w_fs.err;
        end else if (w_fs.zero) begin
            n_out.pitch_cmd    = '0;
            n_out.throttle_cmd = '0;
            n_out.status       = w_fs.sat_neg ? ST_SAT : ST_OK;
        end else begin
            n_out.pitch_cmd    = w_fp.pitch;
            n_out.throttle_cmd = w_ft ? THR_FULL : w_dq[DIV_N];
            n_out.status       = (w_fs.sat_neg || w_fp.sat || w_ft) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[PIPE_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end
endmodule

/* hdl/ptva_cordic_cell.sv */
// One vectoring CORDIC micro-rotation, registered.
module ptva_cordic_cell
    import ptva_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [4:0]         i_idx,
    input  logic signed [41:0] i_x,
    input  logic signed [41:0] i_y,
    input  logic signed [26:0] i_z,
    output logic signed [41:0] o_x,
    output logic signed [41:0] o_y,
    output logic signed [26:0] o_z
);
    logic signed [41:0] xs, ys;
    logic signed [26:0] at;
    logic signed [41:0] n_x, n_y;
    logic signed [26:0] n_z;
    logic signed [41:0] r_x, r_y;
    logic signed [26:0] r_z;

    always_comb begin
        xs = i_x >>> i_idx;
        ys = i_y >>> i_idx;
        at = $signed({1'b0, ATAN_TAB[i_idx]});
        if (!i_y[41]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + at;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* hdl/ptva_sqrt_cell.sv */
// One result bit of a restoring integer square root, registered.
module ptva_sqrt_cell
    import ptva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [4:0]  i_k,
    input  logic [63:0] i_rem,
    input  logic [31:0] i_root,
    output logic [63:0] o_rem,
    output logic [31:0] o_root
);
    logic [65:0] trial;
    logic        fits;
    logic [63:0] n_rem, r_rem;
    logic [31:0] n_root, r_root;

    always_comb begin
        // (root + 2^k)^2 - root^2
        trial = (66'(i_root) << (6'(i_k) + 6'd1)) + (66'd1 << {i_k, 1'b0});
        fits  = {2'b00, i_rem} >= trial;
        n_rem  = fits ? (i_rem - trial[63:0]) : i_rem;
        n_root = fits ? (i_root | (32'd1 << i_k)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

/* hdl/ptva_div_cell.sv */
// One quotient bit of a restoring divider, registered.
module ptva_div_cell
    import ptva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [3:0]  i_k,
    input  logic [48:0] i_rem,
    input  logic [32:0] i_d,
    input  logic [15:0] i_q,
    output logic [48:0] o_rem,
    output logic [32:0] o_d,
    output logic [15:0] o_q
);
    logic [48:0] dk;
    logic        fits;
    logic [48:0] r_rem;
    logic [32:0] r_d;
    logic [15:0] r_q;

    always_comb begin
        dk   = 49'(i_d) << i_k;
        fits = i_rem >= dk;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= fits ? (i_rem - dk) : i_rem;
            r_q   <= fits ? (i_q | (16'd1 << i_k)) : i_q;
            r_d   <= i_d;
        end
    end

    assign o_rem = r_rem;
    assign o_d   = r_d;
    assign o_q   = r_q;
endmodule

/* hdl/ptva_checker.sv */
// Port-level checker for the allocator, bound to the top level.
module ptva_checker
    import ptva_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_data,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NOCFG || o_out_data.status == ST_MASS)
        |-> o_out_data.pitch_cmd == '0 && o_out_data.throttle_cmd == '0)
        else $error("error result carries a command");

    a_thr_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.throttle_cmd <= THR_FULL)
        else $error("throttle above full");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");
endmodule

bind planar_thrust_vector_allocator ptva_checker u_ptva_checker (.*);
